/* rtl/core/cps_pkg.sv */
// ----------------------------------------------------------------------------
// cps_pkg
// shared types and constants for the closest point on segment block
// ----------------------------------------------------------------------------
package cps_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int EPS_WIDTH       = 16;
   localparam logic [EPS_WIDTH-1:0] EPS_RESET = 16'd1;

   typedef enum logic [2:0] {
      FOUND_NEAR_END    = 3'd0,
      FOUND_NEAR_START  = 3'd1,
      FOUND_DEGENERATE  = 3'd2,
      FOUND_PROJECTION  = 3'd3,
      FOUND_CLAMP_START = 3'd4,
      FOUND_CLAMP_END   = 3'd5
   } found_type;

   typedef struct packed {
      logic      valid;
      found_type code;
   } ctl_type;

endpackage

/* rtl/core/cps_front.sv */
// ----------------------------------------------------------------------------
// cps_front
// three stages: differences and products, near tests and selection,
// projection numerator and divisor for the divider row
// ----------------------------------------------------------------------------
module cps_front
   import cps_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [COORD_WIDTH-1:0]     start_x,
   input  logic signed [COORD_WIDTH-1:0]     start_y,
   input  logic signed [COORD_WIDTH-1:0]     end_x,
   input  logic signed [COORD_WIDTH-1:0]     end_y,
   input  logic signed [COORD_WIDTH-1:0]     point_x,
   input  logic signed [COORD_WIDTH-1:0]     point_y,
   input  logic [EPS_WIDTH-1:0]              eps,
   output ctl_type                           ctl_o,
   output logic [COORD_WIDTH-1:0]            base_x_o,
   output logic [COORD_WIDTH-1:0]            base_y_o,
   output logic                              neg_x_o,
   output logic                              neg_y_o,
   output logic [3*COORD_WIDTH+3:0]          num_x_o,
   output logic [3*COORD_WIDTH+3:0]          num_y_o,
   output logic [2*COORD_WIDTH+2:0]          den_o
);

   localparam int W    = COORD_WIDTH;
   localparam int LW   = 2*W + 2;
   localparam int NW   = LW + W + 2;
   localparam int CMPW = (LW > EPS_WIDTH) ? LW : EPS_WIDTH;

   // stage 1
   logic signed [W:0] sx, sy, ex, ey, px, py;
   logic signed [W:0] dx, dy, ax, ay, bx, by;

   logic                    v1_ff, v1_in;
   logic signed [LW-1:0]    p_dx_ff, p_dy_ff, p_ax_ff, p_ay_ff, p_bx_ff, p_by_ff;
   logic signed [LW-1:0]    p_tx_ff, p_ty_ff;
   logic [W-1:0]            sx1_ff, sy1_ff, ex1_ff, ey1_ff;
   logic [W:0]              mx1_ff, my1_ff;
   logic                    nx1_ff, ny1_ff;

   assign sx = {start_x[W-1], start_x};
   assign sy = {start_y[W-1], start_y};
   assign ex = {end_x[W-1], end_x};
   assign ey = {end_y[W-1], end_y};
   assign px = {point_x[W-1], point_x};
   assign py = {point_y[W-1], point_y};
   assign dx = ex - sx;
   assign dy = ey - sy;
   assign ax = px - sx;
   assign ay = py - sy;
   assign bx = px - ex;
   assign by = py - ey;
   assign v1_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_dx_ff <= LW'(dx * dx);
         p_dy_ff <= LW'(dy * dy);
         p_ax_ff <= LW'(ax * ax);
         p_ay_ff <= LW'(ay * ay);
         p_bx_ff <= LW'(bx * bx);
         p_by_ff <= LW'(by * by);
         p_tx_ff <= LW'(dx * ax);
         p_ty_ff <= LW'(dy * ay);
         sx1_ff  <= start_x;
         sy1_ff  <= start_y;
         ex1_ff  <= end_x;
         ey1_ff  <= end_y;
         mx1_ff  <= dx[W] ? (W+1)'(0) - dx : dx;
         my1_ff  <= dy[W] ? (W+1)'(0) - dy : dy;
         nx1_ff  <= dx[W];
         ny1_ff  <= dy[W];
      end
   end

   // stage 2
   logic [LW-1:0]        len, d_start, d_end;
   logic signed [LW:0]   dot;
   logic                 near_end, near_start, degen, on_segment;
   ctl_type              ctl2_ff, ctl2_in;
   logic [W-1:0]         bx2_in, by2_in, bx2_ff, by2_ff;
   logic [LW-1:0]        len2_ff, dot2_ff;
   logic [W:0]           mx2_ff, my2_ff;
   logic                 nx2_ff, ny2_ff;

   assign len     = p_dx_ff + p_dy_ff;
   assign d_start = p_ax_ff + p_ay_ff;
   assign d_end   = p_bx_ff + p_by_ff;
   assign dot     = {p_tx_ff[LW-1], p_tx_ff} + {p_ty_ff[LW-1], p_ty_ff};

   assign near_end   = CMPW'(d_end) < CMPW'(eps);
   assign near_start = CMPW'(d_start) < CMPW'(eps);
   assign degen      = (CMPW'(len) < CMPW'(eps)) || (len == '0);
   assign on_segment = !dot[LW] && ($signed({1'b0, len}) >= dot);

   always_comb begin
      ctl2_in.valid = v1_ff;
      priority if (near_end) begin
         ctl2_in.code = FOUND_NEAR_END;
         bx2_in = ex1_ff;
         by2_in = ey1_ff;
      end else if (near_start) begin
         ctl2_in.code = FOUND_NEAR_START;
         bx2_in = sx1_ff;
         by2_in = sy1_ff;
      end else if (degen) begin
         ctl2_in.code = FOUND_DEGENERATE;
         bx2_in = sx1_ff;
         by2_in = sy1_ff;
      end else if (on_segment) begin
         ctl2_in.code = FOUND_PROJECTION;
         bx2_in = sx1_ff;
         by2_in = sy1_ff;
      end else if (d_start < d_end) begin
         ctl2_in.code = FOUND_CLAMP_START;
         bx2_in = sx1_ff;
         by2_in = sy1_ff;
      end else begin
         ctl2_in.code = FOUND_CLAMP_END;
         bx2_in = ex1_ff;
         by2_in = ey1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
      end else if (en) begin
         ctl2_ff <= ctl2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bx2_ff  <= bx2_in;
         by2_ff  <= by2_in;
         len2_ff <= len;
         dot2_ff <= dot[LW-1:0];
         mx2_ff  <= mx1_ff;
         my2_ff  <= my1_ff;
         nx2_ff  <= nx1_ff;
         ny2_ff  <= ny1_ff;
      end
   end

   // stage 3: rounded quotient numerator 2*dot*m + len over 2*len
   ctl_type             ctl3_ff;
   logic [NW-1:0]       num_x_in, num_y_in;

   assign num_x_in = {(NW-1)'(dot2_ff * mx2_ff), 1'b0} + NW'(len2_ff);
   assign num_y_in = {(NW-1)'(dot2_ff * my2_ff), 1'b0} + NW'(len2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff <= '0;
      end else if (en) begin
         ctl3_ff <= ctl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_x_o  <= num_x_in;
         num_y_o  <= num_y_in;
         den_o    <= {len2_ff, 1'b0};
         base_x_o <= bx2_ff;
         base_y_o <= by2_ff;
         neg_x_o  <= nx2_ff;
         neg_y_o  <= ny2_ff;
      end
   end

   assign ctl_o = ctl3_ff;

endmodule

/* rtl/core/cps_div_cell.sv */
// ----------------------------------------------------------------------------
// cps_div_cell
// one restoring division step for the x and y lanes, passing the item on
// ----------------------------------------------------------------------------
module cps_div_cell
   import cps_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  ctl_type                        ctl_i,
   input  logic [2*COORD_WIDTH+2:0]       den_i,
   input  logic [2*COORD_WIDTH+2:0]       rem_x_i,
   input  logic [2*COORD_WIDTH+2:0]       rem_y_i,
   input  logic [COORD_WIDTH:0]           low_x_i,
   input  logic [COORD_WIDTH:0]           low_y_i,
   input  logic [COORD_WIDTH:0]           q_x_i,
   input  logic [COORD_WIDTH:0]           q_y_i,
   input  logic [COORD_WIDTH-1:0]         base_x_i,
   input  logic [COORD_WIDTH-1:0]         base_y_i,
   input  logic                           neg_x_i,
   input  logic                           neg_y_i,
   output ctl_type                        ctl_o,
   output logic [2*COORD_WIDTH+2:0]       den_o,
   output logic [2*COORD_WIDTH+2:0]       rem_x_o,
   output logic [2*COORD_WIDTH+2:0]       rem_y_o,
   output logic [COORD_WIDTH:0]           low_x_o,
   output logic [COORD_WIDTH:0]           low_y_o,
   output logic [COORD_WIDTH:0]           q_x_o,
   output logic [COORD_WIDTH:0]           q_y_o,
   output logic [COORD_WIDTH-1:0]         base_x_o,
   output logic [COORD_WIDTH-1:0]         base_y_o,
   output logic                           neg_x_o,
   output logic                           neg_y_o
);

   localparam int W  = COORD_WIDTH;
   localparam int DW = 2*W + 3;
   localparam int QW = W + 1;

   logic [DW:0]   sh_x, sh_y, tr_x, tr_y;
   logic [DW-1:0] rem_x_in, rem_y_in;
   logic          bit_x, bit_y;
   ctl_type       ctl_ff;

   assign sh_x  = {rem_x_i, low_x_i[QW-1]};
   assign sh_y  = {rem_y_i, low_y_i[QW-1]};
   assign tr_x  = sh_x - {1'b0, den_i};
   assign tr_y  = sh_y - {1'b0, den_i};
   assign bit_x = (sh_x >= {1'b0, den_i});
   assign bit_y = (sh_y >= {1'b0, den_i});
   assign rem_x_in = bit_x ? tr_x[DW-1:0] : sh_x[DW-1:0];
   assign rem_y_in = bit_y ? tr_y[DW-1:0] : sh_y[DW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_o    <= den_i;
         rem_x_o  <= rem_x_in;
         rem_y_o  <= rem_y_in;
         low_x_o  <= {low_x_i[QW-2:0], 1'b0};
         low_y_o  <= {low_y_i[QW-2:0], 1'b0};
         q_x_o    <= {q_x_i[QW-2:0], bit_x};
         q_y_o    <= {q_y_i[QW-2:0], bit_y};
         base_x_o <= base_x_i;
         base_y_o <= base_y_i;
         neg_x_o  <= neg_x_i;
         neg_y_o  <= neg_y_i;
      end
   end

   assign ctl_o = ctl_ff;

endmodule

/* rtl/core/closest_point_on_segment.sv */
// ----------------------------------------------------------------------------
// closest_point_on_segment
// closest point on a 2-d segment to a query point, fixed point
// ----------------------------------------------------------------------------
// usage:
//   req_ channel takes one item per cycle: segment start, end and a query
//   point. rsp_ channel returns the closest point and how_found.
//   csr_wen/csr_wdata write the near threshold; the user must write it
//   only while the block is idle, which the block itself does not enforce.
// pipeline: three front stages, one divider cell per quotient bit and the
//   output register.
// throughput: one item per cycle, set by the row of divider cells, each
//   doing one quotient bit of the rounded projection.
// stall: while rsp_valid is high and rsp_ready low the whole pipeline
//   holds and req_ready is low; items in flight are kept.
// reset: clears all valid bits and sets the threshold to 1.
// ----------------------------------------------------------------------------
module closest_point_on_segment
   import cps_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_closest_x,
   output logic signed [COORD_WIDTH-1:0] rsp_closest_y,
   output logic [2:0]                    rsp_how_found,
   input  logic                          csr_wen,
   input  logic [EPS_WIDTH-1:0]          csr_wdata
);

   localparam int W  = COORD_WIDTH;
   localparam int DW = 2*W + 3;
   localparam int NW = 3*W + 4;
   localparam int QW = W + 1;

   logic                 en;
   logic [EPS_WIDTH-1:0] eps_ff;
   logic [NW-1:0]        num_x, num_y;

   ctl_type        ctl    [QW+1];
   logic [DW-1:0]  den    [QW+1];
   logic [DW-1:0]  rem_x  [QW+1];
   logic [DW-1:0]  rem_y  [QW+1];
   logic [QW-1:0]  low_x  [QW+1];
   logic [QW-1:0]  low_y  [QW+1];
   logic [QW-1:0]  q_x    [QW+1];
   logic [QW-1:0]  q_y    [QW+1];
   logic [W-1:0]   base_x [QW+1];
   logic [W-1:0]   base_y [QW+1];
   logic           neg_x  [QW+1];
   logic           neg_y  [QW+1];

   logic           rsp_valid_ff;
   logic [W-1:0]   out_x_ff, out_y_ff, out_x_in, out_y_in;
   found_type      code_ff;
   logic [W+1:0]   qx_ext, qy_ext, sum_x, sum_y;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_wen) begin
         eps_ff <= csr_wdata;
      end
   end

   cps_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .start_x  (req_start_x),
      .start_y  (req_start_y),
      .end_x    (req_end_x),
      .end_y    (req_end_y),
      .point_x  (req_point_x),
      .point_y  (req_point_y),
      .eps      (eps_ff),
      .ctl_o    (ctl[0]),
      .base_x_o (base_x[0]),
      .base_y_o (base_y[0]),
      .neg_x_o  (neg_x[0]),
      .neg_y_o  (neg_y[0]),
      .num_x_o  (num_x),
      .num_y_o  (num_y),
      .den_o    (den[0])
   );

   assign rem_x[0] = num_x[NW-1:QW];
   assign rem_y[0] = num_y[NW-1:QW];
   assign low_x[0] = num_x[QW-1:0];
   assign low_y[0] = num_y[QW-1:0];
   assign q_x[0]   = '0;
   assign q_y[0]   = '0;

   for (genvar i = 0; i < QW; i++) begin : g_cell
      cps_div_cell #(.COORD_WIDTH(COORD_WIDTH)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .ctl_i    (ctl[i]),
         .den_i    (den[i]),
         .rem_x_i  (rem_x[i]),
         .rem_y_i  (rem_y[i]),
         .low_x_i  (low_x[i]),
         .low_y_i  (low_y[i]),
         .q_x_i    (q_x[i]),
         .q_y_i    (q_y[i]),
         .base_x_i (base_x[i]),
         .base_y_i (base_y[i]),
         .neg_x_i  (neg_x[i]),
         .neg_y_i  (neg_y[i]),
         .ctl_o    (ctl[i+1]),
         .den_o    (den[i+1]),
         .rem_x_o  (rem_x[i+1]),
         .rem_y_o  (rem_y[i+1]),
         .low_x_o  (low_x[i+1]),
         .low_y_o  (low_y[i+1]),
         .q_x_o    (q_x[i+1]),
         .q_y_o    (q_y[i+1]),
         .base_x_o (base_x[i+1]),
         .base_y_o (base_y[i+1]),
         .neg_x_o  (neg_x[i+1]),
         .neg_y_o  (neg_y[i+1])
      );
   end

   assign qx_ext = {1'b0, q_x[QW]};
   assign qy_ext = {1'b0, q_y[QW]};
   assign sum_x  = neg_x[QW] ? {{2{base_x[QW][W-1]}}, base_x[QW]} - qx_ext
                             : {{2{base_x[QW][W-1]}}, base_x[QW]} + qx_ext;
   assign sum_y  = neg_y[QW] ? {{2{base_y[QW][W-1]}}, base_y[QW]} - qy_ext
                             : {{2{base_y[QW][W-1]}}, base_y[QW]} + qy_ext;

   always_comb begin
      if (ctl[QW].code == FOUND_PROJECTION) begin
         out_x_in = sum_x[W-1:0];
         out_y_in = sum_y[W-1:0];
      end else begin
         out_x_in = base_x[QW];
         out_y_in = base_y[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ctl[QW].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         code_ff  <= ctl[QW].code;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_closest_x = out_x_ff;
   assign rsp_closest_y = out_y_ff;
   assign rsp_how_found = code_ff;

endmodule

/* test/closest_point_on_segment_check.sv */
// ----------------------------------------------------------------------------
// closest_point_on_segment_check
// watches the request and response channels of the closest point block,
// works out the expected closest point for every accepted item and compares
// each response item field by field, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module closest_point_on_segment_check
   import cps_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic signed [15:0]  req_start_x,
   input  logic signed [15:0]  req_start_y,
   input  logic signed [15:0]  req_end_x,
   input  logic signed [15:0]  req_end_y,
   input  logic signed [15:0]  req_point_x,
   input  logic signed [15:0]  req_point_y,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic signed [15:0]  rsp_closest_x,
   input  logic signed [15:0]  rsp_closest_y,
   input  logic [2:0]          rsp_how_found,
   input  logic                csr_wen,
   input  logic [15:0]         csr_wdata,
   output int                  fail_count,
   output int                  pending
);

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      found_type          code;
   } nearest_type;

   nearest_type      nearest_q[$];
   logic [15:0]      threshold;

   assign pending = nearest_q.size();

   function automatic logic signed [15:0] projected(
      logic signed [15:0] origin, logic signed [16:0] delta,
      logic signed [63:0] dot, logic signed [63:0] len);
      logic [63:0] num;
      logic [63:0] quot;
      logic [16:0] span;
      begin
         span = delta < 0 ? -delta : delta;
         num  = 64'(dot) * 64'(span);
         quot = (2 * num + 64'(len)) / (2 * 64'(len));
         projected = delta < 0 ? 16'(origin - 64'(quot)) : 16'(origin + 64'(quot));
      end
   endfunction

   function automatic nearest_type find_nearest(
      logic signed [15:0] sx, logic signed [15:0] sy, logic signed [15:0] ex,
      logic signed [15:0] ey, logic signed [15:0] px, logic signed [15:0] py,
      logic [15:0] eps);
      logic signed [63:0] dx, dy, len, d_start, d_end, dot;
      nearest_type        n;
      begin
         dx      = 64'(ex) - 64'(sx);
         dy      = 64'(ey) - 64'(sy);
         len     = dx * dx + dy * dy;
         d_start = (64'(px) - sx) * (64'(px) - sx) + (64'(py) - sy) * (64'(py) - sy);
         d_end   = (64'(px) - ex) * (64'(px) - ex) + (64'(py) - ey) * (64'(py) - ey);
         dot     = dx * (64'(px) - sx) + dy * (64'(py) - sy);
         if (d_end < 64'(eps)) begin
            n = '{ex, ey, FOUND_NEAR_END};
         end else if (d_start < 64'(eps)) begin
            n = '{sx, sy, FOUND_NEAR_START};
         end else if (len < 64'(eps) || len == 0) begin
            n = '{sx, sy, FOUND_DEGENERATE};
         end else if (dot >= 0 && dot <= len) begin
            n.x    = projected(sx, 17'(dx), dot, len);
            n.y    = projected(sy, 17'(dy), dot, len);
            n.code = FOUND_PROJECTION;
         end else if (d_start < d_end) begin
            n = '{sx, sy, FOUND_CLAMP_START};
         end else begin
            n = '{ex, ey, FOUND_CLAMP_END};
         end
         find_nearest = n;
      end
   endfunction

   always @(posedge clock) begin
      nearest_type want;
      if (reset) begin
         threshold <= EPS_RESET;
      end else begin
         if (csr_wen) begin
            threshold <= csr_wdata;
         end
         if (req_valid && req_ready) begin
            nearest_q.push_back(find_nearest(req_start_x, req_start_y, req_end_x,
               req_end_y, req_point_x, req_point_y, threshold));
         end
         if (rsp_valid && rsp_ready) begin
            if (nearest_q.size() == 0) begin
               $display("%0t: unexpected item x=%0d y=%0d how=%0d", $time,
                  rsp_closest_x, rsp_closest_y, rsp_how_found);
               fail_count++;
            end else begin
               want = nearest_q.pop_front();
               if (rsp_closest_x !== want.x || rsp_closest_y !== want.y ||
                     rsp_how_found !== want.code) begin
                  $display("%0t: expected x=%0d y=%0d how=%0d, got x=%0d y=%0d how=%0d",
                     $time, want.x, want.y, want.code, rsp_closest_x, rsp_closest_y,
                     rsp_how_found);
                  fail_count++;
               end
            end
         end
      end
   end

   initial fail_count = 0;

endmodule

/* test/closest_point_on_segment_test.sv */
// ----------------------------------------------------------------------------
// closest_point_on_segment_test
// drives directed and random segment queries with random gaps and stalls
// through the closest point block over several threshold settings; the
// checker beside the block predicts and compares every response item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module closest_point_on_segment_test;
   import cps_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_start_x, req_start_y, req_end_x, req_end_y;
   logic signed [15:0] req_point_x, req_point_y;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_closest_x, rsp_closest_y;
   logic [2:0]         rsp_how_found;
   logic               csr_wen;
   logic [15:0]        csr_wdata;
   int                 fail_count;
   int                 pending;
   bit                 hold_off;
   bit                 sending;

   closest_point_on_segment i_dut (.*);

   closest_point_on_segment_check i_check (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("closest_point_on_segment test failed");
      $finish;
   end

   function automatic logic signed [15:0] near(logic signed [15:0] c, int spread);
      near = 16'(c + $signed($urandom_range(2 * spread, 0)) - spread);
   endfunction

   task automatic send(logic signed [15:0] sx, logic signed [15:0] sy,
      logic signed [15:0] ex, logic signed [15:0] ey, logic signed [15:0] px,
      logic signed [15:0] py);
      int gap;
      gap = $urandom_range(3, 0);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x   <= ex;
      req_end_y   <= ey;
      req_point_x <= px;
      req_point_y <= py;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic random_item();
      logic signed [15:0] sx, sy, ex, ey, px, py;
      int                 span;
      span = ($urandom_range(3, 0) == 0) ? 32767 : (1 << $urandom_range(12, 0));
      sx = 16'($urandom);
      sy = 16'($urandom);
      ex = near(sx, span);
      ey = near(sy, span);
      case ($urandom_range(5, 0))
         0: begin px = 16'($urandom); py = 16'($urandom); end
         1: begin px = near(sx, 3); py = near(sy, 3); end
         2: begin px = near(ex, 3); py = near(ey, 3); end
         3: begin
            ex = near(sx, 1);
            ey = near(sy, 1);
            px = near(sx, span);
            py = near(sy, span);
         end
         default: begin px = near(sx, 2 * span); py = near(sy, 2 * span); end
      endcase
      send(sx, sy, ex, ey, px, py);
   endtask

   task automatic set_threshold(logic [15:0] value);
      req_valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      csr_wen   <= 1;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 0;
   endtask

   // receiver
   initial begin
      int gap;
      rsp_ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 0;
            repeat (200) @(negedge clock);
            hold_off = 0;
         end
         gap = $urandom_range(3, 0);
         if (gap != 0 && sending) begin
            rsp_ready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      logic [15:0] settings[5];
      settings = '{16'd0, 16'd1, 16'd64, 16'd65535, 16'd4096};
      reset = 1;
      req_valid = 0;
      {req_start_x, req_start_y, req_end_x, req_end_y, req_point_x, req_point_y} = '0;
      csr_wen = 0;
      csr_wdata = 0;
      hold_off = 0;
      sending = 1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // extremes, degenerate, projections, clamps
      send(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
      send(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
      send(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
      send(100, 100, 100, 100, 100, 100);
      send(0, 0, 1024, 0, 512, 700);
      send(0, 0, 1024, 0, -300, 5);
      send(0, 0, 1024, 0, 2000, -5);
      send(0, 0, 3, 0, 1, 9);
      send(0, 0, 2, 2, 2, 0);
      send(-1, -1, 1, 1, -1, 1);
      foreach (settings[i]) begin
         set_threshold(settings[i]);
         send(5, 5, 5, 5, 400, -400);
         send(0, 0, 4, 0, 4, 1);
         send(0, 0, 40, 0, 0, 3);
         if (i == 2) begin
            hold_off = 1;
         end
         repeat (180) random_item();
      end
      req_valid <= 0;
      sending = 0;
      while (pending != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (fail_count == 0) begin
         $display("closest_point_on_segment test passed");
      end else begin
         $display("closest_point_on_segment test failed");
      end
      $finish;
   end

endmodule
